// File: rtl/cls_pkg.sv
// Shared types and constants for the command line argument splitter.
// Parser mode codes, character codes and the control and result structs.
// No dependencies.
`default_nettype none

package cls_pkg;

    // Parameter defaults
    localparam int MAX_ARGS_DEF        = 16;
    localparam int LINE_BUFFER_LEN_DEF = 128;

    // Parser modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_WAIT_CMD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IN_CMD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT_ARG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IN_ARG   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QSTART   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QBODY    = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    // Per-line parser control state
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              comma_sep;
        logic              squote;
        logic              stopped;
    } ctrl_t;

    // Per-byte result flags and data
    typedef struct packed {
        logic [7:0] out_byte;
        logic       starts;
        logic       stopped;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/command_line_argument_splitter.sv
// The result of an input transfer is registered and shows on the m_ side in the next cycle.
// Throughput: one byte per cycle while m_tready holds; the parser step is a single pass of logic
// between the line state registers and the result register.
// s_tready stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous): clears the line state and empties the result register.
`default_nettype none

module command_line_argument_splitter #(
    parameter int MAX_ARGS        = cls_pkg::MAX_ARGS_DEF,
    parameter int LINE_BUFFER_LEN = cls_pkg::LINE_BUFFER_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] first_of_line
    // Results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [14:8] byte_position,
                                        // [19:15] argument_count, [23:20] zero
    output logic [1:0]       m_tuser    // [0] starts_argument, [1] scan_stopped
);

    // Counter widths: the word count reaches MAX_ARGS at most, the position
    // LINE_BUFFER_LEN-1 at most, since the scan stops there.
    localparam int ARG_W = $clog2(MAX_ARGS + 1);
    localparam int POS_W = $clog2(LINE_BUFFER_LEN);

    // Line state
    cls_pkg::ctrl_t   ctrl_reg;
    cls_pkg::ctrl_t   ctrl_next;
    logic [ARG_W-1:0] arg_reg;
    logic [ARG_W-1:0] arg_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    // Result register
    logic             m_valid_reg;
    logic [7:0]       m_byte_reg;
    logic [6:0]       m_pos_reg;
    logic [4:0]       m_argc_reg;
    logic             m_starts_reg;
    logic             m_stopped_reg;

    logic [POS_W-1:0] pos_out;
    cls_pkg::res_t    res;
    logic [31:0]      pos_wide;
    logic [31:0]      arg_wide;
    logic             s_xfer;

    // Accept a byte whenever the result register is free or drains this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    cls_step #(
        .MAX_ARGS        (MAX_ARGS),
        .LINE_BUFFER_LEN (LINE_BUFFER_LEN),
        .ARG_W           (ARG_W),
        .POS_W           (POS_W)
    ) u_step (
        .ctrl          (ctrl_reg),
        .arg_cnt       (arg_reg),
        .pos_cnt       (pos_reg),
        .first_of_line (s_tuser),
        .data_byte     (s_tdata),
        .ctrl_next     (ctrl_next),
        .arg_next      (arg_next),
        .pos_next      (pos_next),
        .pos_out       (pos_out),
        .res           (res)
    );

    // Report only the low bits of the counters on the result fields
    assign pos_wide = 32'(pos_out);
    assign arg_wide = 32'(arg_next);

    // Line state: advance on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            arg_reg  <= '0;
            pos_reg  <= '0;
        end else if (s_xfer) begin
            ctrl_reg <= ctrl_next;
            arg_reg  <= arg_next;
            pos_reg  <= pos_next;
        end
    end

    // Result valid: set on an input transfer, clear when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on an input transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_byte_reg    <= res.out_byte;
            m_pos_reg     <= pos_wide[6:0];
            m_argc_reg    <= arg_wide[4:0];
            m_starts_reg  <= res.starts;
            m_stopped_reg <= res.stopped;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_argc_reg, m_pos_reg, m_byte_reg};
    assign m_tuser  = {m_stopped_reg, m_starts_reg};

`ifndef SYNTHESIS
    // The word count never passes the limit
    a_arg_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(arg_reg) <= MAX_ARGS)
        else $error("argument count above limit");

    // A byte that starts a word is never reported as after the stop
    a_start_not_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("word start flagged on a stopped byte");

    // Within a line the word count and position never go back
    a_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !s_tuser) |-> (arg_next >= arg_reg && pos_next >= pos_reg))
        else $error("line counter went back within a line");

    // Once stopped, a line stays stopped until its next first byte
    a_stop_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !s_tuser && ctrl_reg.stopped) |-> ctrl_next.stopped)
        else $error("scan restarted without a new line");
`endif

endmodule

`default_nettype wire

// File: rtl/cls_step.sv
// Combinational parser step: one byte against the current line state.
// Gives the next line state and the result for that byte.
// Depends on cls_pkg.
`default_nettype none

module cls_step #(
    parameter int MAX_ARGS        = cls_pkg::MAX_ARGS_DEF,
    parameter int LINE_BUFFER_LEN = cls_pkg::LINE_BUFFER_LEN_DEF,
    parameter int ARG_W           = $clog2(MAX_ARGS + 1),
    parameter int POS_W           = $clog2(LINE_BUFFER_LEN)
) (
    input  wire cls_pkg::ctrl_t   ctrl,
    input  wire logic [ARG_W-1:0] arg_cnt,
    input  wire logic [POS_W-1:0] pos_cnt,
    input  wire logic             first_of_line,
    input  wire logic [7:0]       data_byte,
    output cls_pkg::ctrl_t        ctrl_next,
    output logic [ARG_W-1:0]      arg_next,
    output logic [POS_W-1:0]      pos_next,
    output logic [POS_W-1:0]      pos_out,
    output cls_pkg::res_t         res
);

    cls_pkg::ctrl_t   ctrl_eff;
    logic [ARG_W-1:0] arg_eff;
    logic [POS_W-1:0] pos_eff;
    logic             stop_now;
    logic             run;
    logic [7:0]       sep;
    logic [7:0]       quote;
    logic             count;

    always_comb begin
        // Drop the old line state on the first byte of a line
        if (first_of_line) begin
            ctrl_eff = '0;
            arg_eff  = '0;
            pos_eff  = '0;
        end else begin
            ctrl_eff = ctrl;
            arg_eff  = arg_cnt;
            pos_eff  = pos_cnt;
        end

        stop_now = !ctrl_eff.stopped &&
                   ((data_byte inside {cls_pkg::CH_NUL, cls_pkg::CH_CR, cls_pkg::CH_LF}) ||
                    (arg_eff >= ARG_W'(MAX_ARGS)) ||
                    (pos_eff >= POS_W'(LINE_BUFFER_LEN - 1)));
        run   = !(ctrl_eff.stopped || stop_now);
        sep   = ctrl_eff.comma_sep ? cls_pkg::CH_COMMA : cls_pkg::CH_SPACE;
        quote = ctrl_eff.squote ? cls_pkg::CH_SQUOT : cls_pkg::CH_DQUOT;

        ctrl_next         = ctrl_eff;
        ctrl_next.stopped = ctrl_eff.stopped || stop_now;
        res.out_byte      = data_byte;
        res.starts        = 1'b0;
        res.stopped       = ctrl_next.stopped;
        count             = 1'b0;

        if (run) begin
            case (ctrl_eff.mode)
                cls_pkg::MODE_WAIT_CMD: begin
                    if (data_byte != cls_pkg::CH_SPACE) begin
                        res.starts     = 1'b1;
                        count          = 1'b1;
                        ctrl_next.mode = cls_pkg::MODE_IN_CMD;
                    end
                end
                cls_pkg::MODE_IN_CMD: begin
                    if (data_byte == cls_pkg::CH_SPACE) begin
                        ctrl_next.mode = cls_pkg::MODE_WAIT_ARG;
                        res.out_byte   = '0;
                    end else if (data_byte == cls_pkg::CH_EQUAL) begin
                        ctrl_next.comma_sep = 1'b1;
                        ctrl_next.mode      = cls_pkg::MODE_WAIT_ARG;
                        res.out_byte        = '0;
                    end
                end
                cls_pkg::MODE_WAIT_ARG: begin
                    if (data_byte == cls_pkg::CH_SPACE) begin
                        res.out_byte = '0;
                    end else if (data_byte inside {cls_pkg::CH_DQUOT, cls_pkg::CH_SQUOT}) begin
                        ctrl_next.squote = (data_byte == cls_pkg::CH_SQUOT);
                        ctrl_next.mode   = cls_pkg::MODE_QSTART;
                        res.out_byte     = '0;
                    end else begin
                        res.starts = 1'b1;
                        count      = 1'b1;
                        // Empty comma argument: count it, stay waiting
                        if (data_byte == sep) begin
                            ctrl_next.mode = cls_pkg::MODE_WAIT_ARG;
                            res.out_byte   = '0;
                        end else begin
                            ctrl_next.mode = cls_pkg::MODE_IN_ARG;
                        end
                    end
                end
                cls_pkg::MODE_IN_ARG: begin
                    if (data_byte == sep) begin
                        ctrl_next.mode = cls_pkg::MODE_WAIT_ARG;
                        res.out_byte   = '0;
                    end
                end
                cls_pkg::MODE_QSTART: begin
                    res.starts = 1'b1;
                    count      = 1'b1;
                    if (data_byte == quote) begin
                        ctrl_next.mode = cls_pkg::MODE_IN_ARG;
                        res.out_byte   = '0;
                    end else begin
                        ctrl_next.mode = cls_pkg::MODE_QBODY;
                    end
                end
                cls_pkg::MODE_QBODY: begin
                    if (data_byte == quote) begin
                        ctrl_next.mode = cls_pkg::MODE_IN_ARG;
                        res.out_byte   = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        arg_next = arg_eff + ARG_W'(count);
        pos_next = pos_eff + POS_W'(run);
        pos_out  = pos_eff;
    end

endmodule

`default_nettype wire
